[rtl/prmt_pkg.sv]
// Shared constants and types of the pending request match tracker.
package prmt_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 8;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REPLY  = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_FLUSH  = 2'd3;

  localparam logic [2:0] KIND_ACCEPTED   = 3'd0;
  localparam logic [2:0] KIND_FULL       = 3'd1;
  localparam logic [2:0] KIND_COMPLETED  = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT    = 3'd3;
  localparam logic [2:0] KIND_UNEXPECTED = 3'd4;
  localparam logic [2:0] KIND_FLUSHED    = 3'd5;

  localparam logic REG_BUS_NUMBER    = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the input beat, rewind scan
    logic insert;   // write free slot, append to order
    logic step;     // advance scan position
    logic remove;   // remove entry at scan position
    logic dec;      // decrement timer at scan position
    logic clear;    // clear valid of entry at scan position, advance scan
  } prmt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic       drop;     // non-reply read
    logic       full;
    logic       at_end;   // scan position past last entry
    logic       hit;      // reply matches entry at scan position
    logic       armed;
    logic       expire;   // timer at scan position <= 1
    logic       is_error;
  } prmt_sts_t;

endpackage

[rtl/prmt_datapath.sv]
// Entry table, order list, scan pointer and match logic.
module prmt_datapath #(
  parameter int DEPTH    = prmt_pkg::DEPTH_DEF,
  parameter int TAG_BITS = prmt_pkg::TAG_BITS_DEF,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prmt_pkg::prmt_cmd_t cmd_i,
  output prmt_pkg::prmt_sts_t sts_o,
  input  logic [3:0]          bus_number_i,
  input  logic [15:0]         timeout_ticks_i,
  input  logic [1:0]          func_i,
  input  logic [7:0]          tag_i,
  input  logic [2:0]          req_type_i,
  input  logic [3:0]          reply_bus_i,
  input  logic [3:0]          device_number_i,
  input  logic [4:0]          function_number_i,
  input  logic [15:0]         offset_i,
  input  logic [15:0]         offset_mask_i,
  input  logic                arm_timeout_i,
  input  logic                is_reply_i,
  input  logic                is_read_i,
  input  logic                is_error_i,
  output logic [7:0]          scan_tag_o,
  output logic [7:0]          in_tag_o
);

  logic [DEPTH-1:0]    valid_q;
  logic [IW-1:0]       order_q [DEPTH];
  logic [TAG_BITS-1:0] etag_q  [DEPTH];
  logic [2:0]          etype_q [DEPTH];
  logic [3:0]          edev_q  [DEPTH];
  logic [4:0]          efn_q   [DEPTH];
  logic [15:0]         eoff_q  [DEPTH];
  logic [15:0]         emask_q [DEPTH];
  logic [DEPTH-1:0]    armed_q;
  logic [15:0]         timer_q [DEPTH];

  logic [CW-1:0] cnt_q, pos_q;
  logic [1:0]  func_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [2:0]  type_q;
  logic [3:0]  rbus_q, dev_q;
  logic [4:0]  fn_q;
  logic [15:0] off_q, omask_q;
  logic        arm_q, reply_q, read_q, err_q;

  logic [IW-1:0] free_slot, cur;
  logic          has_free;

  always_comb begin
    free_slot = '0;
    has_free  = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = IW'(i);
        has_free  = 1'b1;
      end
    end
  end

  assign cur = order_q[pos_q[IW-1:0]];

  always_comb begin
    sts_o.func     = func_q;
    sts_o.drop     = !reply_q && read_q;
    sts_o.full     = !has_free || (cnt_q >= CW'(DEPTH));
    sts_o.at_end   = pos_q >= cnt_q;
    sts_o.hit      = (etype_q[cur] == type_q) && (edev_q[cur] == dev_q) &&
                     (efn_q[cur] == fn_q) && (rbus_q == bus_number_i) &&
                     ((off_q & emask_q[cur]) == (eoff_q[cur] & emask_q[cur]));
    sts_o.armed    = armed_q[cur];
    sts_o.expire   = timer_q[cur] <= 16'd1;
    sts_o.is_error = err_q;
  end

  assign scan_tag_o = 8'(etag_q[cur]);
  assign in_tag_o   = 8'(tag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        pos_q <= '0;
      end else if (cmd_i.insert) begin
        valid_q[free_slot] <= 1'b1;
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.remove) begin
        valid_q[cur] <= 1'b0;
        cnt_q <= cnt_q - 1'b1;
      end else if (cmd_i.clear) begin
        valid_q[cur] <= 1'b0;
        if (pos_q + 1'b1 >= cnt_q) cnt_q <= '0;
        pos_q <= pos_q + 1'b1;
      end else if (cmd_i.step) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;      tag_q <= TAG_BITS'(tag_i);
      type_q <= req_type_i;  rbus_q <= reply_bus_i;
      dev_q <= device_number_i; fn_q <= function_number_i;
      off_q <= offset_i;     omask_q <= offset_mask_i;
      arm_q <= arm_timeout_i; reply_q <= is_reply_i;
      read_q <= is_read_i;   err_q <= is_error_i;
    end
    if (cmd_i.insert) begin
      etag_q[free_slot]  <= tag_q;
      etype_q[free_slot] <= type_q;
      edev_q[free_slot]  <= dev_q;
      efn_q[free_slot]   <= fn_q;
      eoff_q[free_slot]  <= off_q;
      emask_q[free_slot] <= omask_q;
      armed_q[free_slot] <= arm_q;
      timer_q[free_slot] <= arm_q ? timeout_ticks_i : 16'd0;
      order_q[cnt_q[IW-1:0]] <= free_slot;
    end
    if (cmd_i.dec) timer_q[cur] <= timer_q[cur] - 16'd1;
    // one shift of the order list per remove; positions past count are don't care
    if (cmd_i.remove) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (CW'(i) >= pos_q) order_q[i] <= order_q[i + 1];
      end
    end
  end

endmodule

[rtl/prmt_ctrl.sv]
// Operation sequencer: decodes a beat, walks the order list, emits results.
module prmt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  prmt_pkg::prmt_sts_t sts_i,
  output prmt_pkg::prmt_cmd_t cmd_o,
  input  logic [7:0]          scan_tag_i,
  input  logic [7:0]          in_tag_i,
  output logic                res_valid_o,
  output logic [2:0]          kind_o,
  output logic [7:0]          result_tag_o,
  output logic                status_error_o,
  output logic                last_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEC  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0] state_q, state_d;
  logic       pend_q, pend_d;    // a result is held, waiting to learn if it is last
  logic [2:0] pkind_q, pkind_d;
  logic [7:0] ptag_q, ptag_d;
  logic       perr_q, perr_d;
  logic       emit, emit_last;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    pend_d  = pend_q; pkind_d = pkind_q; ptag_d = ptag_q; perr_d = perr_q;
    emit = 1'b0; emit_last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DEC;
        end
      end
      ST_DEC: begin
        state_d = ST_IDLE;
        unique case (sts_i.func)
          prmt_pkg::FUNC_INSERT: begin
            emit = 1'b1; emit_last = 1'b1;
            pkind_d = sts_i.full ? prmt_pkg::KIND_FULL : prmt_pkg::KIND_ACCEPTED;
            ptag_d = in_tag_i; perr_d = 1'b0;
            cmd_o.insert = !sts_i.full;
          end
          prmt_pkg::FUNC_REPLY: begin
            if (!sts_i.drop) state_d = ST_SCAN;
          end
          default: state_d = ST_SCAN;
        endcase
      end
      default: begin
        if (sts_i.at_end) begin
          state_d = ST_IDLE;
          if (sts_i.func == prmt_pkg::FUNC_REPLY) begin
            emit = 1'b1; emit_last = 1'b1;
            pkind_d = prmt_pkg::KIND_UNEXPECTED; ptag_d = '0; perr_d = 1'b0;
          end else if (pend_q) begin
            emit = 1'b1; emit_last = 1'b1;
          end
          pend_d = 1'b0;
        end else begin
          unique case (sts_i.func)
            prmt_pkg::FUNC_REPLY: begin
              if (sts_i.hit) begin
                emit = 1'b1; emit_last = 1'b1;
                pkind_d = prmt_pkg::KIND_COMPLETED; ptag_d = scan_tag_i;
                perr_d = sts_i.is_error;
                cmd_o.remove = 1'b1;
                state_d = ST_IDLE;
              end else begin
                cmd_o.step = 1'b1;
              end
            end
            prmt_pkg::FUNC_TICK: begin
              if (sts_i.armed && sts_i.expire) begin
                emit = pend_q;
                pend_d = 1'b1; pkind_d = prmt_pkg::KIND_TIMEOUT;
                ptag_d = scan_tag_i; perr_d = 1'b0;
                cmd_o.remove = 1'b1;
              end else begin
                cmd_o.dec  = sts_i.armed;
                cmd_o.step = 1'b1;
              end
            end
            default: begin
              emit = pend_q;
              pend_d = 1'b1; pkind_d = prmt_pkg::KIND_FLUSHED;
              ptag_d = scan_tag_i; perr_d = 1'b0;
              cmd_o.clear = 1'b1;
            end
          endcase
        end
      end
    endcase
  end

  // emitted result: the previous pending one (last only when the scan ends) or the new one (last)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      res_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    pkind_q <= pkind_d; ptag_q <= ptag_d; perr_q <= perr_d;
    if (emit) begin
      if (emit_last && !(pend_q && state_q == ST_SCAN && sts_i.func != prmt_pkg::FUNC_REPLY
                         && !sts_i.at_end)) begin
        kind_o <= pkind_d; result_tag_o <= ptag_d; status_error_o <= perr_d;
        last_o <= 1'b1;
      end else if (state_q == ST_SCAN && sts_i.at_end) begin
        kind_o <= pkind_q; result_tag_o <= ptag_q; status_error_o <= perr_q;
        last_o <= 1'b1;
      end else begin
        kind_o <= pkind_q; result_tag_o <= ptag_q; status_error_o <= perr_q;
        last_o <= 1'b0;
      end
    end
  end

  assign busy_o = state_q != ST_IDLE;

endmodule

[rtl/pending_request_match_tracker.sv]
// Top level of the pending request match tracker.
//  channel | signals                                   | dir | handshake
//  command | start, busy, func_i .. is_error_i         | in  | start && !busy
//  result  | res_valid_o, kind_o .. last_o            | out | res_valid_o, one cycle
//  config  | cfg_valid_i, cfg_ready_o, cfg_idx_i, ... | in  | cfg_valid_i && cfg_ready_o
// An insert or a dropped read is accepted and decoded. A reply that hits also walks
// the entries up to and including the hit; an unmatched reply, a tick and a flush walk
// every entry in the table, one compare per cycle.
// Results come at most one per cycle; the last one shows in the cycle in which busy drops.
// No clearing pass after reset. The result side has no back pressure; config is always ready.
module pending_request_match_tracker #(
  parameter int DEPTH    = prmt_pkg::DEPTH_DEF,
  parameter int TAG_BITS = prmt_pkg::TAG_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [7:0]  tag_i,
  input  logic [2:0]  req_type_i,
  input  logic [3:0]  reply_bus_i,
  input  logic [3:0]  device_number_i,
  input  logic [4:0]  function_number_i,
  input  logic [15:0] offset_i,
  input  logic [15:0] offset_mask_i,
  input  logic        arm_timeout_i,
  input  logic        is_reply_i,
  input  logic        is_read_i,
  input  logic        is_error_i,
  output logic        res_valid_o,
  output logic [2:0]  kind_o,
  output logic [7:0]  result_tag_o,
  output logic        status_error_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  prmt_pkg::prmt_cmd_t cmd;
  prmt_pkg::prmt_sts_t sts;
  logic [7:0]  scan_tag, in_tag;
  logic [3:0]  bus_q;
  logic [15:0] tmo_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q <= '0;
      tmo_q <= prmt_pkg::TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        prmt_pkg::REG_BUS_NUMBER:    bus_q <= cfg_data_i[3:0];
        prmt_pkg::REG_TIMEOUT_TICKS: tmo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  prmt_datapath #(.DEPTH(DEPTH), .TAG_BITS(TAG_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .bus_number_i(bus_q), .timeout_ticks_i(tmo_q),
    .func_i, .tag_i, .req_type_i, .reply_bus_i, .device_number_i,
    .function_number_i, .offset_i, .offset_mask_i, .arm_timeout_i,
    .is_reply_i, .is_read_i, .is_error_i,
    .scan_tag_o(scan_tag), .in_tag_o(in_tag)
  );

  prmt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .sts_i(sts), .cmd_o(cmd),
    .scan_tag_i(scan_tag), .in_tag_i(in_tag),
    .res_valid_o, .kind_o, .result_tag_o, .status_error_o, .last_o
  );

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("beat not taken");
  a_idle_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !(cmd.insert || cmd.remove || cmd.step || cmd.clear || cmd.dec))
    else $error("table command while idle");

endmodule

[tb/tb_pending_request_match_tracker.sv]
// Self-checking testbench for the pending request match tracker.
module tb_pending_request_match_tracker;

  localparam int NSLOTS = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN = 40;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  tag;
    logic [2:0]  rtype;
    logic [3:0]  rbus;
    logic [3:0]  dev;
    logic [4:0]  fn;
    logic [15:0] off;
    logic [15:0] mask;
    logic        arm;
    logic        rep;
    logic        rd;
    logic        err;
  } cmd_t;

  typedef struct {
    logic [7:0]  tag;
    logic [2:0]  rtype;
    logic [3:0]  dev;
    logic [4:0]  fn;
    logic [15:0] off;
    logic [15:0] mask;
    logic        armed;
    logic [15:0] timer;
  } pend_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tag;
    logic       err;
    logic       last;
  } outcome_t;

  logic clk_i, rst_ni;
  logic start, busy;
  logic [1:0] func_i;
  logic [7:0] tag_i;
  logic [2:0] req_type_i;
  logic [3:0] reply_bus_i, device_number_i;
  logic [4:0] function_number_i;
  logic [15:0] offset_i, offset_mask_i;
  logic arm_timeout_i, is_reply_i, is_read_i, is_error_i;
  logic res_valid_o, status_error_o, last_o;
  logic [2:0] kind_o;
  logic [7:0] result_tag_o;
  logic cfg_valid_i, cfg_ready_o, cfg_idx_i;
  logic [15:0] cfg_data_i;

  pending_request_match_tracker dut (.*);

  // predictor state
  pend_t       pend_q[$];
  outcome_t    outcome_q[$];
  logic [3:0]  cur_bus;
  logic [15:0] cur_ticks;
  bit          failed;
  int          cycles;
  int          beat_no;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[pending_request_match_tracker] ERROR");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && res_valid_o) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d tag %0d", $time, kind_o, result_tag_o);
        failed = 1'b1;
      end else begin
        e = outcome_q.pop_front();
        if (kind_o !== e.kind || result_tag_o !== e.tag || status_error_o !== e.err ||
            last_o !== e.last) begin
          $display("%0t: exp kind %0d tag %0d err %0d last %0d, got %0d %0d %0d %0d",
                   $time, e.kind, e.tag, e.err, e.last,
                   kind_o, result_tag_o, status_error_o, last_o);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic void push_outcome(logic [2:0] kind, logic [7:0] tag, logic err);
    outcome_t o;
    o.kind = kind;
    o.tag  = tag;
    o.err  = err;
    o.last = 1'b0;
    outcome_q.push_back(o);
  endfunction

  // update tracker model, return number of new outcomes
  function automatic int track_beat(cmd_t c);
    pend_t p;
    int    n0, i;
    n0 = outcome_q.size();
    case (c.func)
      prmt_pkg::FUNC_INSERT: begin
        if (pend_q.size() >= NSLOTS) push_outcome(prmt_pkg::KIND_FULL, c.tag, 1'b0);
        else begin
          p.tag = c.tag; p.rtype = c.rtype; p.dev = c.dev; p.fn = c.fn;
          p.off = c.off; p.mask = c.mask; p.armed = c.arm;
          p.timer = c.arm ? cur_ticks : 16'd0;
          pend_q.push_back(p);
          push_outcome(prmt_pkg::KIND_ACCEPTED, c.tag, 1'b0);
        end
      end
      prmt_pkg::FUNC_REPLY: begin
        if (c.rep || !c.rd) begin
          for (i = 0; i < pend_q.size(); i++)
            if (pend_q[i].rtype == c.rtype && pend_q[i].dev == c.dev &&
                pend_q[i].fn == c.fn && c.rbus == cur_bus &&
                ((c.off ^ pend_q[i].off) & pend_q[i].mask) == 16'd0) break;
          if (i < pend_q.size()) begin
            push_outcome(prmt_pkg::KIND_COMPLETED, pend_q[i].tag, c.err);
            pend_q.delete(i);
          end else push_outcome(prmt_pkg::KIND_UNEXPECTED, 8'd0, 1'b0);
        end
      end
      prmt_pkg::FUNC_TICK: begin
        i = 0;
        while (i < pend_q.size()) begin
          if (pend_q[i].armed && pend_q[i].timer <= 16'd1) begin
            push_outcome(prmt_pkg::KIND_TIMEOUT, pend_q[i].tag, 1'b0);
            pend_q.delete(i);
          end else begin
            if (pend_q[i].armed) pend_q[i].timer = pend_q[i].timer - 16'd1;
            i++;
          end
        end
      end
      default: begin
        foreach (pend_q[j]) push_outcome(prmt_pkg::KIND_FLUSHED, pend_q[j].tag, 1'b0);
        pend_q.delete();
      end
    endcase
    if (outcome_q.size() > n0) outcome_q[outcome_q.size() - 1].last = 1'b1;
    return outcome_q.size() - n0;
  endfunction

  function automatic cmd_t mk(logic [1:0] f, logic [7:0] t, logic [2:0] ty, logic [3:0] b,
                              logic [3:0] d, logic [4:0] fn, logic [15:0] o,
                              logic [15:0] m, logic a, logic rp, logic rd, logic er);
    cmd_t c;
    c.func = f; c.tag = t; c.rtype = ty; c.rbus = b; c.dev = d; c.fn = fn;
    c.off = o; c.mask = m; c.arm = a; c.rep = rp; c.rd = rd; c.err = er;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   k;
    c.func = 2'($urandom); c.tag = 8'($urandom); c.rtype = 3'($urandom);
    c.rbus = 4'($urandom); c.dev = 4'($urandom); c.fn = 5'($urandom);
    c.off = 16'($urandom); c.mask = 16'($urandom); c.arm = 1'($urandom);
    c.rep = 1'($urandom); c.rd = 1'($urandom); c.err = 1'($urandom);
    k = $urandom_range(99, 0);
    if (k < 45) c.func = prmt_pkg::FUNC_INSERT;
    else if (k < 78) begin
      c.func = prmt_pkg::FUNC_REPLY;
      // mostly well-formed replies aimed at a pending request
      if (pend_q.size() > 0 && $urandom_range(9, 0) < 7) begin
        k = $urandom_range(pend_q.size() - 1, 0);
        c.rtype = pend_q[k].rtype; c.dev = pend_q[k].dev; c.fn = pend_q[k].fn;
        c.off = pend_q[k].off ^ (16'($urandom) & ~pend_q[k].mask);
        c.rbus = cur_bus; c.rep = 1'b1;
      end
    end else if (k < 95) c.func = prmt_pkg::FUNC_TICK;
    else c.func = prmt_pkg::FUNC_FLUSH;
    return c;
  endfunction

  task automatic send(cmd_t c, bit may_idle, output int nres);
    @(negedge clk_i);
    if (may_idle && $urandom_range(99, 0) < 14) begin
      start = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    func_i = c.func; tag_i = c.tag; req_type_i = c.rtype; reply_bus_i = c.rbus;
    device_number_i = c.dev; function_number_i = c.fn; offset_i = c.off;
    offset_mask_i = c.mask; arm_timeout_i = c.arm; is_reply_i = c.rep;
    is_read_i = c.rd; is_error_i = c.err;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    nres = track_beat(c);
    beat_no++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start = 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1; cfg_idx_i = idx; cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == prmt_pkg::REG_BUS_NUMBER) cur_bus = data[3:0];
    else cur_ticks = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  cmd_t     dir_tbl[13];
  bit       dir_chk[13];
  outcome_t dir_exp[13];

  initial begin
    int n, ph;
    start = 1'b0; func_i = prmt_pkg::FUNC_TICK; tag_i = '0; req_type_i = '0;
    reply_bus_i = '0; device_number_i = '0; function_number_i = '0; offset_i = '0;
    offset_mask_i = '0; arm_timeout_i = 1'b0; is_reply_i = 1'b0; is_read_i = 1'b0;
    is_error_i = 1'b0;
    cfg_valid_i = 1'b0; cfg_idx_i = prmt_pkg::REG_BUS_NUMBER; cfg_data_i = '0;
    cur_bus = 4'd0; cur_ticks = prmt_pkg::TIMEOUT_RESET; failed = 1'b0; cycles = 0;
    beat_no = 0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, drop rule, bus and mask mismatches, field extremes
    dir_tbl[0]  = mk(prmt_pkg::FUNC_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tbl[1]  = mk(prmt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tbl[2]  = mk(prmt_pkg::FUNC_REPLY, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    dir_tbl[3]  = mk(prmt_pkg::FUNC_REPLY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
    dir_tbl[4]  = mk(prmt_pkg::FUNC_INSERT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tbl[5]  = mk(prmt_pkg::FUNC_INSERT, 8'hff, 7, 15, 15, 31, 16'hffff, 16'hffff,
                     1, 1, 1, 1);
    dir_tbl[6]  = mk(prmt_pkg::FUNC_INSERT, 8'h5a, 3, 0, 2, 4, 16'h1234, 16'h0000,
                     1, 0, 0, 0);
    dir_tbl[7]  = mk(prmt_pkg::FUNC_REPLY, 0, 3, 0, 2, 4, 16'habcd, 0, 0, 1, 0, 1);
    dir_tbl[8]  = mk(prmt_pkg::FUNC_REPLY, 0, 7, 15, 15, 31, 16'hffff, 0, 0, 1, 1, 0);
    dir_tbl[9]  = mk(prmt_pkg::FUNC_REPLY, 0, 7, 0, 15, 31, 16'hfffe, 0, 0, 1, 1, 0);
    dir_tbl[10] = mk(prmt_pkg::FUNC_REPLY, 0, 7, 0, 15, 31, 16'hffff, 0, 0, 0, 0, 0);
    dir_tbl[11] = mk(prmt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tbl[12] = mk(prmt_pkg::FUNC_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_chk = '{0, 0, 1, 0, 1, 1, 1, 1, 1, 1, 1, 0, 1};
    dir_exp[2]  = '{prmt_pkg::KIND_UNEXPECTED, 8'h00, 1'b0, 1'b1};
    dir_exp[4]  = '{prmt_pkg::KIND_ACCEPTED, 8'h00, 1'b0, 1'b1};
    dir_exp[5]  = '{prmt_pkg::KIND_ACCEPTED, 8'hff, 1'b0, 1'b1};
    dir_exp[6]  = '{prmt_pkg::KIND_ACCEPTED, 8'h5a, 1'b0, 1'b1};
    dir_exp[7]  = '{prmt_pkg::KIND_COMPLETED, 8'h5a, 1'b1, 1'b1};
    dir_exp[8]  = '{prmt_pkg::KIND_UNEXPECTED, 8'h00, 1'b0, 1'b1};
    dir_exp[9]  = '{prmt_pkg::KIND_UNEXPECTED, 8'h00, 1'b0, 1'b1};
    dir_exp[10] = '{prmt_pkg::KIND_COMPLETED, 8'hff, 1'b0, 1'b1};
    dir_exp[12] = '{prmt_pkg::KIND_FLUSHED, 8'h00, 1'b0, 1'b1};

    foreach (dir_tbl[r]) begin
      send(dir_tbl[r], 1'b0, n);
      if (dir_chk[r] && (n != 1 || outcome_q[outcome_q.size() - 1] != dir_exp[r])) begin
        $display("%0t: row %0d exp kind %0d tag %0d, predicted %0d results", $time, r,
                 dir_exp[r].kind, dir_exp[r].tag, n);
        failed = 1'b1;
      end
    end

    // random phases over register settings, extremes included
    for (ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(prmt_pkg::REG_BUS_NUMBER, 16'd15);
          write_reg(prmt_pkg::REG_TIMEOUT_TICKS, 16'd1);
        end
        1: begin
          write_reg(prmt_pkg::REG_BUS_NUMBER, 16'd5);
          write_reg(prmt_pkg::REG_TIMEOUT_TICKS, 16'd3);
        end
        2: begin
          write_reg(prmt_pkg::REG_BUS_NUMBER, 16'd0);
          write_reg(prmt_pkg::REG_TIMEOUT_TICKS, 16'hffff);
        end
        default: begin
          write_reg(prmt_pkg::REG_BUS_NUMBER, 16'd10);
          write_reg(prmt_pkg::REG_TIMEOUT_TICKS, 16'd2);
        end
      endcase
      // overfill the table once
      if (ph == 1)
        repeat (NSLOTS + 1)
          send(mk(prmt_pkg::FUNC_INSERT, 8'($urandom), 3'($urandom), 4'd0, 4'($urandom),
                  5'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                  1'b0, 1'b0, 1'b0), 1'b1, n);
      repeat (19) send(rand_cmd(), !(ph == 2), n);
      send(mk(prmt_pkg::FUNC_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, n);
    end

    @(negedge clk_i);
    start = 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (!failed) $display("[pending_request_match_tracker] OK");
    else $display("[pending_request_match_tracker] ERROR");
    $finish;
  end

endmodule
